// ===== hdl/rbe_pkg.sv =====
// Package for the rigid body Euler step: item types, register map, reset values
// and the shared fixed-point helpers (saturation, rounding, factor multiply).
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package rbe_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned UNIT_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DT_W      = 17;
  localparam int unsigned GRAV_W    = 22;
  localparam int unsigned FAC_W     = 17;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_TIME_STEP      = 3'd0;
  localparam logic [2:0] REG_GRAVITY        = 3'd1;
  localparam logic [2:0] REG_FLOOR_LEVEL    = 3'd2;
  localparam logic [2:0] REG_BOUNCE_FACTOR  = 3'd3;
  localparam logic [2:0] REG_DAMPING_FACTOR = 3'd4;

  localparam logic [DT_W-1:0]          TIME_STEP_RST      = 17'd1092;
  localparam logic [GRAV_W-1:0]        GRAVITY_RST        = 22'd642908;
  localparam logic signed [DATA_W-1:0] FLOOR_LEVEL_RST    = 32'sd32768;
  localparam logic [FAC_W-1:0]         BOUNCE_FACTOR_RST  = 17'd19661;
  localparam logic [FAC_W-1:0]         DAMPING_FACTOR_RST = 17'd64225;

  localparam logic [DATA_W-1:0] S32_MAX_BITS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN_BITS = 32'h8000_0000;
  localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
    logic [DATA_W-1:0]        mass;
    logic                     is_static;
    logic                     is_active;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_pos_z;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
    logic signed [DATA_W-1:0] new_vel_z;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  // Clamp to the 32 bit signed range; hit reports clipping.
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > S32_MAX_W) begin
      r.hit = 1'b1;
      r.val = S32_MAX_BITS;
    end else if (v < S32_MIN_W) begin
      r.hit = 1'b1;
      r.val = S32_MIN_BITS;
    end else begin
      r.hit = 1'b0;
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Round to nearest after dropping sh fraction bits, ties toward +infinity.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  // Signed 33 bit value times an unsigned 17 bit factor.
  function automatic logic signed [50:0] mul_fac(input logic signed [32:0] a,
                                                  input logic [FAC_W-1:0] b);
    logic signed [50:0] ae;
    logic signed [50:0] be;
    ae = 51'(a);
    be = 51'(b);
    return ae * be;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rigid_body_euler_step.sv =====
// Rigid body Euler step. Throughput one item per cycle while in_stall_o is low; a 32-stage
// restoring divider (one quotient bit per stage, three lanes) for force/mass sets the
// depth, plus nine arithmetic stages.
// A skid register at the output keeps input open while one result waits.
// Reset (rst_ni, async, active low) empties the pipeline and restores register defaults.
// Uses rbe_pkg for item types, register map and fixed-point helpers.
`default_nettype none

module rigid_body_euler_step #(
  parameter int unsigned FRAC_BITS = rbe_pkg::FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rbe_pkg::in_item_t             in_item_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rbe_pkg::out_item_t            out_item_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbe_pkg::APB_AW-1:0]    paddr,
  input  logic [rbe_pkg::APB_DW-1:0]    pwdata,
  output logic [rbe_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  // The divider produces one quotient bit per stage. Quotients of 2^32 or more
  // are detected up front, so only the low 32 bits are iterated.
  localparam int unsigned DIV_STEPS   = rbe_pkg::DATA_W;
  localparam int unsigned HI_SH       = rbe_pkg::DATA_W - FRAC_BITS;
  localparam int unsigned POST_STAGES = 9;

  typedef logic [2:0][rbe_pkg::DATA_W-1:0] vec3_t;
  typedef logic [2:0][50:0]                prod3_t;

  // What travels with every item: current position and velocity, whether the
  // object is simulated, whether mass is zero, and the running clip flag.
  typedef struct packed {
    logic  run;
    logic  mz;
    logic  sat;
    vec3_t pos;
    vec3_t vel;
  } obj_t;

  typedef struct packed {
    logic                      neg;
    logic                      ovf;
    logic [rbe_pkg::DATA_W-1:0] rem;
    logic [rbe_pkg::DATA_W-1:0] dq;
  } dlane_t;

  typedef struct packed {
    obj_t                       obj;
    logic [rbe_pkg::DATA_W-1:0] mass;
    dlane_t [2:0]               ln;
  } dstage_t;

  typedef struct packed {
    obj_t  obj;
    vec3_t acc;
  } acc_t;

  typedef struct packed {
    obj_t   obj;
    prod3_t prod;
  } mul_t;

  typedef struct packed {
    obj_t        obj;
    logic        bn;
    logic [50:0] prodb;
  } bnc_t;

  // One restoring division step: bring in the next dividend bit, subtract the
  // divisor if it fits, and shift the quotient bit into the vacated position.
  function automatic dlane_t div_step(input dlane_t s, input logic [rbe_pkg::DATA_W-1:0] m);
    dlane_t      r;
    logic [32:0] t;
    logic [32:0] diff;
    t    = {s.rem, s.dq[rbe_pkg::DATA_W-1]};
    diff = t - {1'b0, m};
    r    = s;
    if (t >= {1'b0, m}) begin
      r.rem = diff[rbe_pkg::DATA_W-1:0];
      r.dq  = {s.dq[rbe_pkg::DATA_W-2:0], 1'b1};
    end else begin
      r.rem = t[rbe_pkg::DATA_W-1:0];
      r.dq  = {s.dq[rbe_pkg::DATA_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. Write them only while the pipeline is empty (not enforced
  // by the block), so the stages read these registers directly instead of carrying copies.
  // ---------------------------------------------------------------------------
  logic [rbe_pkg::DT_W-1:0]          dt_q;
  logic [rbe_pkg::GRAV_W-1:0]        grav_q;
  logic signed [rbe_pkg::DATA_W-1:0] floor_q;
  logic [rbe_pkg::FAC_W-1:0]         bounce_q;
  logic [rbe_pkg::FAC_W-1:0]         damp_q;
  logic [2:0]                        reg_idx;
  logic                              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rbe_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q     <= rbe_pkg::TIME_STEP_RST;
      grav_q   <= rbe_pkg::GRAVITY_RST;
      floor_q  <= rbe_pkg::FLOOR_LEVEL_RST;
      bounce_q <= rbe_pkg::BOUNCE_FACTOR_RST;
      damp_q   <= rbe_pkg::DAMPING_FACTOR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        rbe_pkg::REG_TIME_STEP:      dt_q     <= pwdata[rbe_pkg::DT_W-1:0];
        rbe_pkg::REG_GRAVITY:        grav_q   <= pwdata[rbe_pkg::GRAV_W-1:0];
        rbe_pkg::REG_FLOOR_LEVEL:    floor_q  <= pwdata[rbe_pkg::DATA_W-1:0];
        rbe_pkg::REG_BOUNCE_FACTOR:  bounce_q <= pwdata[rbe_pkg::FAC_W-1:0];
        rbe_pkg::REG_DAMPING_FACTOR: damp_q   <= pwdata[rbe_pkg::FAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rbe_pkg::REG_TIME_STEP:      prdata = 32'(dt_q);
      rbe_pkg::REG_GRAVITY:        prdata = 32'(grav_q);
      rbe_pkg::REG_FLOOR_LEVEL:    prdata = floor_q;
      rbe_pkg::REG_BOUNCE_FACTOR:  prdata = 32'(bounce_q);
      rbe_pkg::REG_DAMPING_FACTOR: prdata = 32'(damp_q);
      default:                     prdata = '0;
    endcase
  end

  // The gravity term round(gravity * dt) is the same for every item, so it is
  // kept in a register that follows the configuration in the next cycle. Items
  // pass the input, divider and stage 1 to 3 registers before the stage that uses it.
  logic [38:0] gprod;
  logic [32:0] gdt_d;
  logic [32:0] gdt_q;

  assign gprod = 39'(grav_q) * 39'(dt_q);
  assign gdt_d = 33'(rbe_pkg::round_shift(64'(gprod), FRAC_BITS));

  always_ff @(posedge clk_i) begin
    gdt_q <= gdt_d;
  end

  // ---------------------------------------------------------------------------
  // Flow control. All stages advance together whenever the skid register is
  // empty. With the output register full and stalled, the pipeline still advances,
  // parking the arriving item in the skid register; only then is the input
  // stalled. Nothing is dropped or repeated.
  // ---------------------------------------------------------------------------
  logic                       en;
  logic                       p0_vld_q;
  logic [DIV_STEPS:0]         div_vld_q;
  logic [POST_STAGES-1:0]     post_vld_q;
  logic                       out_vld_q;
  logic                       skid_vld_q;
  logic                       push;
  logic                       pop;

  assign en         = !skid_vld_q;
  assign in_stall_o = !en;
  assign push       = en && post_vld_q[POST_STAGES-1];
  assign pop        = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q   <= 1'b0;
      div_vld_q  <= '0;
      post_vld_q <= '0;
    end else if (en) begin
      p0_vld_q   <= in_valid_i;
      div_vld_q  <= {div_vld_q[DIV_STEPS-1:0], p0_vld_q};
      post_vld_q <= {post_vld_q[POST_STAGES-2:0], div_vld_q[DIV_STEPS]};
    end
  end

  // ---------------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------------
  rbe_pkg::in_item_t p0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q <= in_item_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider setup. The dividend is |force| << FRAC_BITS. Its part above bit 31
  // is compared against mass: if it is not smaller, the quotient is at least
  // 2^32 and the acceleration will clip. Otherwise that part is exactly the
  // partial remainder after the upper quotient bits, all of them zero.
  // ---------------------------------------------------------------------------
  dstage_t div_q [DIV_STEPS+1];
  dstage_t div0_d;

  always_comb begin
    vec3_t                      frc;
    logic [rbe_pkg::DATA_W-1:0] mag;
    logic [rbe_pkg::DATA_W-1:0] hi;
    frc = {p0_q.force_z, p0_q.force_y, p0_q.force_x};
    div0_d.obj.run = p0_q.is_active && !p0_q.is_static;
    div0_d.obj.mz  = (p0_q.mass == '0);
    div0_d.obj.sat = 1'b0;
    div0_d.obj.pos = {p0_q.pos_z, p0_q.pos_y, p0_q.pos_x};
    div0_d.obj.vel = {p0_q.vel_z, p0_q.vel_y, p0_q.vel_x};
    div0_d.mass    = p0_q.mass;
    for (int l = 0; l < 3; l++) begin
      mag = frc[l][rbe_pkg::DATA_W-1] ? (~frc[l] + 32'd1) : frc[l];
      hi  = mag >> HI_SH;
      div0_d.ln[l].neg = frc[l][rbe_pkg::DATA_W-1];
      div0_d.ln[l].ovf = (hi >= p0_q.mass);
      div0_d.ln[l].rem = hi;
      div0_d.ln[l].dq  = mag << FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0] <= div0_d;
    end
  end

  // Divider body: one quotient bit per stage for each of the three lanes.
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    dstage_t step_d;

    always_comb begin
      step_d = div_q[k-1];
      for (int l = 0; l < 3; l++) begin
        step_d.ln[l] = div_step(div_q[k-1].ln[l], div_q[k-1].mass);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[k] <= step_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: apply the sign and clip the acceleration to 32 bits. A negative
  // quotient of exactly 2^31 is representable and does not count as clipping.
  // ---------------------------------------------------------------------------
  acc_t q1_d;
  acc_t q1_q;

  always_comb begin
    logic [rbe_pkg::DATA_W-1:0] q;
    logic                       hit;
    q1_d.obj = div_q[DIV_STEPS].obj;
    hit      = 1'b0;
    for (int l = 0; l < 3; l++) begin
      q = div_q[DIV_STEPS].ln[l].dq;
      if (div_q[DIV_STEPS].ln[l].neg) begin
        if (div_q[DIV_STEPS].ln[l].ovf || (q > rbe_pkg::S32_MIN_BITS)) begin
          q1_d.acc[l] = rbe_pkg::S32_MIN_BITS;
          hit         = 1'b1;
        end else begin
          q1_d.acc[l] = ~q + 32'd1;
        end
      end else begin
        if (div_q[DIV_STEPS].ln[l].ovf || q[rbe_pkg::DATA_W-1]) begin
          q1_d.acc[l] = rbe_pkg::S32_MAX_BITS;
          hit         = 1'b1;
        end else begin
          q1_d.acc[l] = q;
        end
      end
    end
    if (q1_d.obj.run && !q1_d.obj.mz) begin
      q1_d.obj.sat = q1_d.obj.sat | hit;
    end
  end

  // Stage 2: acceleration times dt.
  mul_t q2_d;
  mul_t q2_q;

  always_comb begin
    q2_d.obj = q1_q.obj;
    for (int l = 0; l < 3; l++) begin
      q2_d.prod[l] = rbe_pkg::mul_fac(33'($signed(q1_q.acc[l])), dt_q);
    end
  end

  // Stage 3: velocity gains the rounded force term, unless mass is zero.
  obj_t q3_d;
  obj_t q3_q;

  always_comb begin
    rbe_pkg::sat_t s;
    q3_d = q2_q.obj;
    for (int l = 0; l < 3; l++) begin
      s = rbe_pkg::sat32(64'($signed(q2_q.obj.vel[l]))
                         + rbe_pkg::round_shift(64'($signed(q2_q.prod[l])), FRAC_BITS));
      if (q2_q.obj.run && !q2_q.obj.mz) begin
        q3_d.vel[l] = s.val;
        q3_d.sat    = q3_d.sat | s.hit;
      end
    end
  end

  // Stage 4: gravity is taken off the vertical velocity.
  obj_t q4_d;
  obj_t q4_q;

  always_comb begin
    rbe_pkg::sat_t s;
    q4_d = q3_q;
    s    = rbe_pkg::sat32(64'($signed(q3_q.vel[1])) - 64'(gdt_q));
    if (q3_q.run) begin
      q4_d.vel[1] = s.val;
      q4_d.sat    = q4_d.sat | s.hit;
    end
  end

  // Stage 5: new velocity times dt.
  mul_t q5_d;
  mul_t q5_q;

  always_comb begin
    q5_d.obj = q4_q;
    for (int l = 0; l < 3; l++) begin
      q5_d.prod[l] = rbe_pkg::mul_fac(33'($signed(q4_q.vel[l])), dt_q);
    end
  end

  // Stage 6: position advances.
  obj_t q6_d;
  obj_t q6_q;

  always_comb begin
    rbe_pkg::sat_t s;
    q6_d = q5_q.obj;
    for (int l = 0; l < 3; l++) begin
      s = rbe_pkg::sat32(64'($signed(q5_q.obj.pos[l]))
                         + rbe_pkg::round_shift(64'($signed(q5_q.prod[l])), FRAC_BITS));
      if (q5_q.obj.run) begin
        q6_d.pos[l] = s.val;
        q6_d.sat    = q6_d.sat | s.hit;
      end
    end
  end

  // Stage 7: floor clamp. The bounce product of the negated vertical velocity
  // is formed here and used in the next stage only if the object fell below
  // the floor while moving down.
  bnc_t q7_d;
  bnc_t q7_q;

  always_comb begin
    logic below;
    below    = q6_q.run && ($signed(q6_q.pos[1]) < floor_q);
    q7_d.obj = q6_q;
    q7_d.bn  = below && q6_q.vel[1][rbe_pkg::DATA_W-1];
    if (below) begin
      q7_d.obj.pos[1] = floor_q;
    end
    q7_d.prodb = rbe_pkg::mul_fac(-33'($signed(q6_q.vel[1])), bounce_q);
  end

  // Stage 8: bounce.
  obj_t q8_d;
  obj_t q8_q;

  always_comb begin
    rbe_pkg::sat_t s;
    q8_d = q7_q.obj;
    s    = rbe_pkg::sat32(rbe_pkg::round_shift(64'($signed(q7_q.prodb)), rbe_pkg::UNIT_BITS));
    if (q7_q.bn) begin
      q8_d.vel[1] = s.val;
      q8_d.sat    = q8_d.sat | s.hit;
    end
  end

  // Stage 9: velocity times the damping factor.
  mul_t q9_d;
  mul_t q9_q;

  always_comb begin
    q9_d.obj = q8_q;
    for (int l = 0; l < 3; l++) begin
      q9_d.prod[l] = rbe_pkg::mul_fac(33'($signed(q8_q.vel[l])), damp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_q <= q1_d;
      q2_q <= q2_d;
      q3_q <= q3_d;
      q4_q <= q4_d;
      q5_q <= q5_d;
      q6_q <= q6_d;
      q7_q <= q7_d;
      q8_q <= q8_d;
      q9_q <= q9_d;
    end
  end

  // Final rounding of the damped velocity, then the result item.
  rbe_pkg::out_item_t res_d;

  always_comb begin
    rbe_pkg::sat_t s;
    obj_t          o;
    o = q9_q.obj;
    for (int l = 0; l < 3; l++) begin
      s = rbe_pkg::sat32(rbe_pkg::round_shift(64'($signed(q9_q.prod[l])),
                                              rbe_pkg::UNIT_BITS));
      if (q9_q.obj.run) begin
        o.vel[l] = s.val;
        o.sat    = o.sat | s.hit;
      end
    end
    res_d.new_pos_x = o.pos[0];
    res_d.new_pos_y = o.pos[1];
    res_d.new_pos_z = o.pos[2];
    res_d.new_vel_x = o.vel[0];
    res_d.new_vel_y = o.vel[1];
    res_d.new_vel_z = o.vel[2];
    res_d.saturated = o.sat;
  end

  // ---------------------------------------------------------------------------
  // Output register with skid register. The skid register fills only when the
  // output register holds an item that is not being taken.
  // ---------------------------------------------------------------------------
  rbe_pkg::out_item_t out_q;
  rbe_pkg::out_item_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || pop) begin
      out_vld_q  <= skid_vld_q || push;
      skid_vld_q <= 1'b0;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  // The skid register is only ever used behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds an item while the output register is empty");

  // After the last divider stage the remainder is below the divisor whenever
  // the quotient was in range and mass is nonzero.
  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld_q[DIV_STEPS] && !div_q[DIV_STEPS].obj.mz) |->
      ((div_q[DIV_STEPS].ln[0].ovf || (div_q[DIV_STEPS].ln[0].rem < div_q[DIV_STEPS].mass)) &&
       (div_q[DIV_STEPS].ln[1].ovf || (div_q[DIV_STEPS].ln[1].rem < div_q[DIV_STEPS].mass)) &&
       (div_q[DIV_STEPS].ln[2].ovf || (div_q[DIV_STEPS].ln[2].rem < div_q[DIV_STEPS].mass))))
    else $error("divider remainder not below divisor");

  // A static or inactive object never reports clipping.
  a_passthrough_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (post_vld_q[POST_STAGES-1] && !q9_q.obj.run) |-> !q9_q.obj.sat)
    else $error("clip flag set on an object that is not simulated");

  // A bounce is only scheduled for an object that was clamped to the floor.
  a_bounce_on_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (post_vld_q[6] && q7_q.bn) |-> ($signed(q7_q.obj.pos[1]) == floor_q))
    else $error("bounce scheduled for an object not on the floor");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_rigid_body_euler_step.sv =====
// Self-checking testbench for rigid_body_euler_step: drives object items, predicts each
// integrated state, and compares every result field with the prediction.
// Depends on rbe_pkg for the item types, register indexes and reset values.
`timescale 1ns / 100ps

module tb_rigid_body_euler_step;

  // One Q16.16 unit, used to write readable directed objects.
  localparam int U = 65536;
  // The tail wait covers the pipeline depth of the block with margin.
  localparam int TAIL_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 210;
  localparam int NUM_PHASES = 8;
  // A register index past the end of the map; writes to it must change nothing.
  localparam logic [2:0] REG_UNUSED = 3'd5;

  // Handshake patterns: none, sender gaps, receiver stalls, both.
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  rbe_pkg::in_item_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  rbe_pkg::out_item_t out_item_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rbe_pkg::APB_AW-1:0] paddr;
  logic [rbe_pkg::APB_DW-1:0] pwdata;
  logic [rbe_pkg::APB_DW-1:0] prdata;
  logic pready;

  // Shadow copy of the configuration registers, as the block should hold them.
  logic [rbe_pkg::DT_W-1:0]          cfg_dt;
  logic [rbe_pkg::GRAV_W-1:0]        cfg_grav;
  logic signed [rbe_pkg::DATA_W-1:0] cfg_floor;
  logic [rbe_pkg::FAC_W-1:0]         cfg_bounce;
  logic [rbe_pkg::FAC_W-1:0]         cfg_damp;

  rbe_pkg::in_item_t  objects_q [$];
  rbe_pkg::out_item_t next_states_q [$];
  idle_mode_e idle_mode;

  int objects_pushed;
  int objects_offered;
  int objects_accepted;
  int states_checked;
  int n_err;
  int cycles;
  int phases_run;

  logic [31:0] want_w [7];
  logic [31:0] got_w [7];
  string fld_name [7];

  rigid_body_euler_step uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the step, done in 64-bit integers.
  // ---------------------------------------------------------------------------

  // Clamp to the signed 32-bit range; hit is set when anything is clipped.
  function automatic longint clip32(input longint v, inout bit hit);
    if (v > rbe_pkg::S32_MAX_W) begin
      hit = 1'b1;
      return rbe_pkg::S32_MAX_W;
    end
    if (v < rbe_pkg::S32_MIN_W) begin
      hit = 1'b1;
      return rbe_pkg::S32_MIN_W;
    end
    return v;
  endfunction

  // Drop sh fraction bits, rounding to nearest with ties toward +infinity.
  // The arithmetic shift of a signed 64-bit value is a floor division.
  function automatic longint rnd_shift(input longint v, input int unsigned sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Next state of one object under the current register settings.
  function automatic rbe_pkg::out_item_t integrate_object(input rbe_pkg::in_item_t o);
    longint p [3];
    longint v [3];
    longint f [3];
    longint a;
    longint dt;
    longint unsigned mag;
    longint unsigned m;
    bit hit;
    rbe_pkg::out_item_t r;
    int i;
    p[0] = longint'(o.pos_x);
    p[1] = longint'(o.pos_y);
    p[2] = longint'(o.pos_z);
    v[0] = longint'(o.vel_x);
    v[1] = longint'(o.vel_y);
    v[2] = longint'(o.vel_z);
    f[0] = longint'(o.force_x);
    f[1] = longint'(o.force_y);
    f[2] = longint'(o.force_z);
    m = {32'd0, o.mass};
    dt = longint'(cfg_dt);
    hit = 1'b0;
    // Static or inactive objects pass through untouched and never flag.
    if (o.is_active && !o.is_static) begin
      // Force term: the quotient truncates toward zero and is clipped
      // before it is scaled by dt. Zero mass skips it entirely.
      if (m != 0) begin
        for (i = 0; i < 3; i++) begin
          mag = (f[i] < 0) ? -f[i] : f[i];
          a = longint'((mag << rbe_pkg::FRAC_BITS) / m);
          if (f[i] < 0) a = -a;
          a = clip32(a, hit);
          v[i] = clip32(v[i] + rnd_shift(a * dt, rbe_pkg::FRAC_BITS), hit);
        end
      end
      v[1] = clip32(v[1] - rnd_shift(longint'(cfg_grav) * dt, rbe_pkg::FRAC_BITS), hit);
      // Semi-implicit: position moves with the already updated velocity.
      for (i = 0; i < 3; i++)
        p[i] = clip32(p[i] + rnd_shift(v[i] * dt, rbe_pkg::FRAC_BITS), hit);
      if (p[1] < longint'(cfg_floor)) begin
        p[1] = longint'(cfg_floor);
        if (v[1] < 0)
          v[1] = clip32(rnd_shift(-v[1] * longint'(cfg_bounce), rbe_pkg::UNIT_BITS), hit);
      end
      for (i = 0; i < 3; i++)
        v[i] = clip32(rnd_shift(v[i] * longint'(cfg_damp), rbe_pkg::UNIT_BITS), hit);
    end
    r.new_pos_x = p[0][31:0];
    r.new_pos_y = p[1][31:0];
    r.new_pos_z = p[2][31:0];
    r.new_vel_x = v[0][31:0];
    r.new_vel_y = v[1][31:0];
    r.new_vel_z = v[2][31:0];
    r.saturated = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic rbe_pkg::in_item_t make_object(
    input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
    input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
    input logic [31:0] fx, input logic [31:0] fy, input logic [31:0] fz,
    input logic [31:0] m, input logic st, input logic act);
    rbe_pkg::in_item_t o;
    o.pos_x = px;
    o.pos_y = py;
    o.pos_z = pz;
    o.vel_x = vx;
    o.vel_y = vy;
    o.vel_z = vz;
    o.force_x = fx;
    o.force_y = fy;
    o.force_z = fz;
    o.mass = m;
    o.is_static = st;
    o.is_active = act;
    return o;
  endfunction

  // A signed Q16.16 value: full random, small, medium or one of the extremes.
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    int unsigned sel;
    sel = $urandom_range(99);
    w = $urandom();
    if (sel < 30) return w;
    if (sel < 70) return int'($urandom_range(0, 200 * U)) - 100 * U;
    if (sel < 85) return {{9{w[31]}}, w[22:0]};
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(9))
      0: return 32'd0;
      1, 2, 3, 4, 5: return $urandom_range(U / 4, 100 * U);
      6: return $urandom_range(1, 255);
      7, 8: return $urandom();
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Mostly live objects with random content; a few static or inactive ones.
  // Height is often placed close to the floor so clamping and bounce happen.
  function automatic rbe_pkg::in_item_t rand_object();
    rbe_pkg::in_item_t o;
    bit dummy;
    longint near_y;
    o = make_object(rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_word(), rand_word(),
                    rand_mass(), 1'b0, 1'b1);
    if ($urandom_range(99) < 40) begin
      near_y = longint'(cfg_floor) + longint'(int'($urandom_range(0, 4 * U)) - 2 * U);
      o.pos_y = 32'(clip32(near_y, dummy));
      if ($urandom_range(1)) o.vel_y = -int'($urandom_range(0, 20 * U));
    end
    if ($urandom_range(9) >= 8) begin
      o.is_static = 1'($urandom_range(1));
      o.is_active = 1'($urandom_range(1));
    end
    return o;
  endfunction

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // APB write: setup cycle, then access cycle; the shadow follows at the
  // edge where the register takes the value.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      rbe_pkg::REG_TIME_STEP:      cfg_dt = val[rbe_pkg::DT_W-1:0];
      rbe_pkg::REG_GRAVITY:        cfg_grav = val[rbe_pkg::GRAV_W-1:0];
      rbe_pkg::REG_FLOOR_LEVEL:    cfg_floor = val;
      rbe_pkg::REG_BOUNCE_FACTOR:  cfg_bounce = val[rbe_pkg::FAC_W-1:0];
      rbe_pkg::REG_DAMPING_FACTOR: cfg_damp = val[rbe_pkg::FAC_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_all(input logic [31:0] dt, input logic [31:0] grav,
                         input logic [31:0] flr, input logic [31:0] bnc,
                         input logic [31:0] dmp);
    cfg_write(rbe_pkg::REG_TIME_STEP, dt);
    cfg_write(rbe_pkg::REG_GRAVITY, grav);
    cfg_write(rbe_pkg::REG_FLOOR_LEVEL, flr);
    cfg_write(rbe_pkg::REG_BOUNCE_FACTOR, bnc);
    cfg_write(rbe_pkg::REG_DAMPING_FACTOR, dmp);
  endtask

  // Block until every pushed item has been accepted and every result checked.
  task automatic wait_drained();
    do @(negedge clk_i); while (objects_accepted != objects_pushed || next_states_q.size() != 0);
  endtask

  task automatic push_object(input rbe_pkg::in_item_t o);
    objects_q = {objects_q, o};
    objects_pushed++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. An offered item stays on the
  // bus until the rising edge that accepts it, and valid never looks at stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    int unsigned gap_pct;
    int unsigned stall_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 79 : (idle_mode == IDLE_BOTH) ? 28 : 0;
    stall_pct = (idle_mode == IDLE_RECEIVER) ? 79 : (idle_mode == IDLE_BOTH) ? 28 : 0;
    if (rst_ni) begin
      if (!in_valid_i || objects_accepted == objects_offered) begin
        if (objects_q.size() != 0 && !chance(gap_pct)) begin
          in_item_i  <= objects_q.pop_front();
          in_valid_i <= 1'b1;
          objects_offered++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= chance(stall_pct);
    end
  end

  // Input side: every accepted item gets its expected state queued here.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      next_states_q = {next_states_q, integrate_object(in_item_i)};
      objects_accepted++;
    end
  end

  // Output side: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    rbe_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (next_states_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item_o);
      end else begin
        want = next_states_q.pop_front();
        states_checked++;
        want_w = '{want.new_pos_x, want.new_pos_y, want.new_pos_z,
                   want.new_vel_x, want.new_vel_y, want.new_vel_z, {31'd0, want.saturated}};
        got_w = '{out_item_o.new_pos_x, out_item_o.new_pos_y, out_item_o.new_pos_z,
                  out_item_o.new_vel_x, out_item_o.new_vel_y, out_item_o.new_vel_z,
                  {31'd0, out_item_o.saturated}};
        for (int k = 0; k < 7; k++) begin
          if (got_w[k] !== want_w[k]) begin
            n_err++;
            $display("%0t: %s expected %h actual %h", $time, fld_name[k], want_w[k], got_w[k]);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, next_states_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    fld_name = '{"new_pos_x", "new_pos_y", "new_pos_z",
                 "new_vel_x", "new_vel_y", "new_vel_z", "saturated"};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_mode = IDLE_NONE;
    objects_pushed = 0;
    objects_offered = 0;
    objects_accepted = 0;
    states_checked = 0;
    n_err = 0;
    cycles = 0;
    phases_run = 0;
    cfg_dt = rbe_pkg::TIME_STEP_RST;
    cfg_grav = rbe_pkg::GRAVITY_RST;
    cfg_floor = rbe_pkg::FLOOR_LEVEL_RST;
    cfg_bounce = rbe_pkg::BOUNCE_FACTOR_RST;
    cfg_damp = rbe_pkg::DAMPING_FACTOR_RST;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed objects under the reset settings (dt about 1/60 s, floor 0.5).
    // Static, inactive and both: result must equal the input, no flag.
    push_object(make_object(12 * U, 3 * U, -7 * U, 5 * U, -4 * U, 2 * U,
                            100 * U, 50 * U, -20 * U, 2 * U, 1'b1, 1'b1));
    push_object(make_object(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 1'b0, 1'b0));
    push_object(make_object(U, 2 * U, 3 * U, 4 * U, 5 * U, 6 * U,
                            7 * U, 8 * U, 9 * U, U, 1'b1, 1'b0));
    // Zero mass: the force term is skipped.
    push_object(make_object(0, 10 * U, 0, U, 0, -U, 1000 * U, 1000 * U, 1000 * U,
                            0, 1'b0, 1'b1));
    // Ordinary object well above the floor.
    push_object(make_object(U, 5 * U, -U, 3 * U, 4 * U, 0, 10 * U, -20 * U, 5 * U,
                            2 * U, 1'b0, 1'b1));
    // Huge acceleration from the smallest nonzero mass: clipped and flagged.
    push_object(make_object(0, 100 * U, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h1, 1'b0, 1'b1));
    // Largest mass: the quotient almost vanishes.
    push_object(make_object(0, 100 * U, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
    // Most negative force over unit mass: exactly in range, no clipping.
    push_object(make_object(0, 100 * U, 0, 0, 0, 0, 32'h8000_0000, 0, 0,
                            U, 1'b0, 1'b1));
    // Truncation toward zero of a tiny negative quotient.
    push_object(make_object(0, 100 * U, 0, 0, 0, 0, -1, -1, 1, 3 * U, 1'b0, 1'b1));
    // Below the floor falling: clamp and bounce.
    push_object(make_object(0, 0, 0, 0, -8 * U, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    // Below the floor rising: clamp only.
    push_object(make_object(0, -10 * U, 0, 0, 2 * U, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    // Resting exactly on the floor: gravity pulls it under, then it bounces.
    push_object(make_object(0, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    // Fastest fall through the floor.
    push_object(make_object(0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    // Position and velocity at the positive extreme: positions clip.
    push_object(make_object(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, U, 1'b0, 1'b1));
    // Negative extreme: velocity and position both clip.
    push_object(make_object(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, U, 1'b0, 1'b1));
    // All zero and all ones.
    push_object(make_object(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    push_object(make_object(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 1'b0, 1'b1));
    wait_drained();

    // Random phases, each with its own register settings and handshake pattern.
    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      idle_mode = idle_mode_e'(ph % 4);
      case (ph)
        1: cfg_all(rbe_pkg::TIME_STEP_RST, rbe_pkg::GRAVITY_RST, rbe_pkg::FLOOR_LEVEL_RST,
                   rbe_pkg::BOUNCE_FACTOR_RST, rbe_pkg::DAMPING_FACTOR_RST);
        // Every register field at its largest value: factors above 1.0 amplify.
        2: cfg_all(32'h1_FFFF, 32'h3F_FFFF, 32'h7FFF_FFFF, 32'h1_FFFF, 32'h1_FFFF);
        // Everything at zero, floor at its lowest.
        3: cfg_all(0, 0, 32'h8000_0000, 0, 0);
        // Top of the stated ranges.
        4: cfg_all(65536, 2097152, -100 * U, 65536, 65536);
        // Full 32-bit writes: bits above each register must be dropped, and
        // a write past the register map must change nothing.
        6: begin
          cfg_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
          cfg_write(REG_UNUSED, $urandom());
        end
        default: cfg_all($urandom_range(1, 4096), $urandom_range(0, 2097152),
                         int'($urandom_range(0, 20 * U)) - 10 * U,
                         $urandom_range(0, 65536), $urandom_range(0, 65536));
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) push_object(rand_object());
      wait_drained();
      phases_run++;
    end

    idle_mode = IDLE_NONE;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d objects (%0d results checked) over %0d register settings",
             objects_pushed, states_checked, phases_run + 1);
    $display("with free flow, sender gaps, receiver stalls and both; %0d mismatches.", n_err);
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== rigid_body_euler_step.f =====
hdl/rbe_pkg.sv
hdl/rigid_body_euler_step.sv
tb/sv/tb_rigid_body_euler_step.sv
